@@ sv/b64enc_pkg.sv @@
// shared types and the alphabet function for the base64 stream encoder
`default_nettype none

package b64enc_pkg;

    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [7:0] PadChar  = 8'h3D;
    localparam logic [5:0] SixMask  = 6'h3F;

    // character slot within one output group
    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;
    localparam logic [1:0] SLOT_FOURTH = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_item_t;

    // one complete or flushed group handed from front to back
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  total;
        logic        last;
    } group_entry_t;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] wide;
        wide = {2'b00, idx & SixMask};
        if (idx < 6'd26)
            return 8'd65 + wide;
        else if (idx < 6'd52)
            return 8'd97 + (wide - 8'd26);
        else if (idx < 6'd62)
            return 8'd48 + (wide - 8'd52);
        else if (idx == 6'd62)
            return 8'd43;
        else
            return 8'd47;
    endfunction

endpackage

`default_nettype wire

@@ sv/b64enc_front.sv @@
// input side: holds pending bytes and forms 24-bit groups
`default_nettype none

module b64enc_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     byte_valid,
    output logic                          byte_stall,
    input  wire b64enc_pkg::in_item_t     byte_data,
    input  wire logic                     queue_full,
    output logic                          push,
    output b64enc_pkg::group_entry_t      push_entry
);
    import b64enc_pkg::*;

    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic        transfer;
    logic        hold_only;

    assign byte_stall = queue_full;
    assign transfer   = byte_valid && !byte_stall;
    assign hold_only  = !byte_data.end_of_message && (held_count_reg < 2'd2);

    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        push            = 1'b0;
        push_entry.last = byte_data.end_of_message;
        case (held_count_reg)
            2'd0:
            begin
                push_entry.group = {byte_data.data_byte, 16'h0000};
                push_entry.total = 2'd1;
            end
            2'd1:
            begin
                push_entry.group = {held_bytes_reg[7:0], byte_data.data_byte, 8'h00};
                push_entry.total = 2'd2;
            end
            default:
            begin
                // count of three never occurs, treated as two
                push_entry.group = {held_bytes_reg, byte_data.data_byte};
                push_entry.total = 2'd3;
            end
        endcase
        if (transfer)
        begin
            if (hold_only)
            begin
                held_bytes_next = {held_bytes_reg[7:0], byte_data.data_byte};
                held_count_next = held_count_reg + 2'd1;
            end
            else
            begin
                push            = 1'b1;
                held_bytes_next = 16'h0000;
                held_count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= 16'h0000;
            held_count_reg <= 2'd0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/b64enc_queue.sv @@
// short group queue between the front and the back
`default_nettype none

module b64enc_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire b64enc_pkg::group_entry_t push_entry,
    output logic                          full,
    input  wire logic                     pop,
    output logic                          head_valid,
    output b64enc_pkg::group_entry_t      head_entry
);
    import b64enc_pkg::*;

    group_entry_t         slot_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0] count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (count_reg == QueueCntW'(QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/b64enc_back.sv @@
// output side: walks each group, one char per cycle unless stalled, into out_reg
`default_nettype none

module b64enc_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     head_valid,
    input  wire b64enc_pkg::group_entry_t head_entry,
    output logic                          pop,
    output logic                          char_valid,
    input  wire logic                     char_stall,
    output b64enc_pkg::out_item_t         char_data
);
    import b64enc_pkg::*;

    group_entry_t cur_reg, cur_next;
    logic         cur_valid_reg, cur_valid_next;
    logic [1:0]   slot_reg, slot_next;
    logic         out_valid_reg, out_valid_next;
    out_item_t    out_reg, out_next;
    logic         advance;
    logic [5:0]   sextet;
    logic         is_pad;

    assign advance = cur_valid_reg && (!out_valid_reg || !char_stall);
    assign pop     = !cur_valid_reg || (advance && slot_reg == SLOT_FOURTH);

    always_comb
    begin
        case (slot_reg)
            SLOT_FIRST:  sextet = cur_reg.group[23:18];
            SLOT_SECOND: sextet = cur_reg.group[17:12];
            SLOT_THIRD:  sextet = cur_reg.group[11:6];
            default:     sextet = cur_reg.group[5:0];
        endcase
        is_pad = ((slot_reg == SLOT_THIRD) && (cur_reg.total < 2'd2))
              || ((slot_reg == SLOT_FOURTH) && (cur_reg.total < 2'd3));
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        slot_next      = slot_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && char_stall;
        if (advance)
        begin
            out_valid_next    = 1'b1;
            out_next.out_char = is_pad ? PadChar : b64_char(sextet);
            out_next.out_last = (slot_reg == SLOT_FOURTH) && cur_reg.last;
            slot_next         = slot_reg + 2'd1;
        end
        if (pop)
        begin
            cur_valid_next = head_valid;
            cur_next       = head_entry;
            slot_next      = SLOT_FIRST;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            slot_reg      <= SLOT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign char_valid = out_valid_reg;
    assign char_data  = out_reg;

endmodule

`default_nettype wire

@@ sv/base64_stream_encoder.sv @@
// base64 stream encoder, top level
// Usage: raw bytes enter on the byte channel (byte_valid, byte_stall,
// byte_data), one byte per transfer, end_of_message set on the final byte.
// Encoded characters leave on the char channel (char_valid, char_stall,
// char_data), one character per transfer, out_last set on the final one.
// Every third byte, or any byte flagged end_of_message, yields a group of
// four characters; a short final group is padded with '='.
// The group closed by a byte transfer is registered in the group queue,
// then in the back end's current group and then in its output register.
// The back end gives one character per cycle from its output register
// while char_stall is low; each three bytes give four characters.
// The front accepts a byte every cycle while the two-entry group queue has
// room; bytes that are only held never wait on the queue being drained
// unless it is full.
// Reset clears the held bytes, the queue and the output register; no
// character is valid after reset.
// When the receiver stalls, the current character holds on char_data; the
// queue fills and then byte_stall rises until the back end moves again.
`default_nettype none

module base64_stream_encoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_stall,
    input  wire b64enc_pkg::in_item_t byte_data,
    output logic                      char_valid,
    input  wire logic                 char_stall,
    output b64enc_pkg::out_item_t     char_data
);
    import b64enc_pkg::*;

    logic         push;
    group_entry_t push_entry;
    logic         queue_full;
    logic         pop;
    logic         head_valid;
    group_entry_t head_entry;

    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    b64enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    b64enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

endmodule

`default_nettype wire

@@ sv/b64enc_checker.sv @@
// port-level checker for the base64 stream encoder and its bind
`default_nettype none

module b64enc_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  char_valid,
    input wire logic                  char_stall,
    input wire b64enc_pkg::out_item_t char_data
);
    import b64enc_pkg::*;

    // output register comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !char_valid)
        else $error("char_valid high right after reset");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid)
        else $error("char_valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> $stable(char_data))
        else $error("char_data changed while stalled");

    // every character is from the alphabet or the pad
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |->
            (char_data.out_char >= 8'd65 && char_data.out_char <= 8'd90)
         || (char_data.out_char >= 8'd97 && char_data.out_char <= 8'd122)
         || (char_data.out_char >= 8'd48 && char_data.out_char <= 8'd57)
         || char_data.out_char == 8'd43 || char_data.out_char == 8'd47
         || char_data.out_char == PadChar)
        else $error("illegal output character");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (.*);

`default_nettype wire
